// ===== rtl/hst_pkg.sv =====
// Shared types and constants of the hashed symbol table.
package hst_pkg;

    // FNV-1a 64-bit constants.
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [7:0]  FNV_PRIME_LOW = 8'hb3;

    // Result status codes.
    localparam logic [2:0] ST_NOT_FOUND = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_INSERTED  = 3'd2;
    localparam logic [2:0] ST_PRESENT   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    // Commands.
    localparam logic CMD_SEARCH = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // One complete name handed from the front to the back.
    typedef struct packed {
        logic        cmd;
        logic        overflow;
        logic [63:0] hash;
    } t_job;

    // One result word.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] slot;
    } t_res;

    // One FNV-1a step; the prime is 2^40 + 2^8 + 0xb3.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x * {56'd0, FNV_PRIME_LOW});
    endfunction

endpackage

// ===== rtl/hashed_symbol_table.sv =====
// Top level of the hashed symbol table: front, job queue, back and result register.
//
//  channel  | direction | handshake        | words
//  ---------+-----------+------------------+-------------------------------------
//  name in  | input     | push / full      | i_cmd, i_name_byte, i_name_last,
//           |           |                  | i_type_word
//  result   | output    | empty / pop      | o_status, o_slot
//
// A byte that is not the last of its name is absorbed by the front end.
// The last byte is carried out by the back end: it reduces the hash to the home slot
// one 16-bit hash digit at a time, then probes slots and compares their characters,
// and writes the characters when inserting; a lookup can sweep every slot.
// After reset the slot memory is cleared with full high.
// Two names can be queued between front and back; full rises when both wait.
module hashed_symbol_table #(
    parameter int TABLE_DEPTH    = 256,
    parameter int MAX_NAME_CHARS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [7:0]  i_name_byte,
    input  logic        i_name_last,
    input  logic [63:0] i_type_word,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [7:0]  o_slot
);
    localparam int LW = $clog2(MAX_NAME_CHARS + 1);
    localparam int KW = $clog2(2 * MAX_NAME_CHARS);

    logic          key_we;
    logic [KW-1:0] key_waddr;
    logic [7:0]    key_wdata;
    logic [KW-1:0] key_raddr;
    logic [7:0]    key_rdata;
    logic          job_push;
    hst_pkg::t_job job_in;
    logic [LW-1:0] len_in;
    logic          job_done;
    logic          res_valid;
    hst_pkg::t_res res;
    logic          res_ready;
    logic          clearing;

    hst_pkg::t_job r_q_job [2];
    logic [LW-1:0] r_q_len [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          r_out_valid;
    hst_pkg::t_res r_out;

    assign full = (r_cnt == 2'd2) || clearing;

    hst_front #(.MAX_NAME_CHARS(MAX_NAME_CHARS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_bank     (r_wp),
        .i_cmd      (i_cmd),
        .i_name_byte(i_name_byte),
        .i_name_last(i_name_last),
        .o_key_we   (key_we),
        .o_key_waddr(key_waddr),
        .o_key_wdata(key_wdata),
        .o_job_push (job_push),
        .o_job      (job_in),
        .o_job_len  (len_in)
    );

    // Key buffer, one bank per queue entry.
    hst_ram #(.WIDTH(8), .DEPTH(2 * MAX_NAME_CHARS)) u_key (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(key_waddr),
        .i_wdata(key_wdata),
        .i_raddr(key_raddr),
        .o_rdata(key_rdata)
    );

    hst_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_NAME_CHARS(MAX_NAME_CHARS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(r_cnt != 2'd0),
        .i_job      (r_q_job[r_rp]),
        .i_job_len  (r_q_len[r_rp]),
        .i_job_bank (r_rp),
        .o_job_done (job_done),
        .o_key_raddr(key_raddr),
        .i_key_rdata(key_rdata),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_ready(res_ready),
        .o_clearing (clearing)
    );

    // Job queue between front and back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (job_push) begin
                r_wp <= !r_wp;
            end
            if (job_done) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, job_push} - {1'b0, job_done};
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_push) begin
            r_q_job[r_wp] <= job_in;
            r_q_len[r_wp] <= len_in;
        end
    end

    // Result register toward the consumer.
    assign res_ready = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign empty    = !r_out_valid;
    assign o_status = r_out.status;
    assign o_slot   = r_out.slot;
endmodule

// ===== rtl/hst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/hst_front.sv =====
// Front end: hashes name bytes, buffers the key and forms one job per name.
module hst_front #(
    parameter int MAX_NAME_CHARS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic                                  i_bank,
    input  logic                                  i_cmd,
    input  logic [7:0]                            i_name_byte,
    input  logic                                  i_name_last,
    output logic                                  o_key_we,
    output logic [$clog2(2*MAX_NAME_CHARS)-1:0]   o_key_waddr,
    output logic [7:0]                            o_key_wdata,
    output logic                                  o_job_push,
    output hst_pkg::t_job                         o_job,
    output logic [$clog2(MAX_NAME_CHARS+1)-1:0]   o_job_len
);
    localparam int LW = $clog2(MAX_NAME_CHARS + 1);
    localparam int KW = $clog2(2 * MAX_NAME_CHARS);

    logic [63:0]   r_hash;
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic          accept;
    logic          room;
    logic [63:0]   n_hash;
    logic [LW-1:0] n_len;
    logic          n_ovf;

    assign accept = i_push && !i_full;
    assign room   = (r_len < LW'(MAX_NAME_CHARS));
    assign n_hash = hst_pkg::fnv_step(r_hash, i_name_byte);
    assign n_len  = room ? r_len + LW'(1) : r_len;
    assign n_ovf  = r_ovf || !room;

    // Key bytes go to the bank that belongs to the queue entry being filled.
    assign o_key_we    = accept && room;
    assign o_key_waddr = (i_bank ? KW'(MAX_NAME_CHARS) : KW'(0)) + KW'(r_len);
    assign o_key_wdata = i_name_byte;

    // The last byte closes the name and hands a job over.
    assign o_job_push    = accept && i_name_last;
    assign o_job.cmd      = i_cmd;
    assign o_job.overflow = n_ovf;
    assign o_job.hash     = n_hash;
    assign o_job_len      = n_len;

    // Running hash, length and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= hst_pkg::FNV_BASIS;
            r_len  <= '0;
            r_ovf  <= 1'b0;
        end else if (accept) begin
            if (i_name_last) begin
                r_hash <= hst_pkg::FNV_BASIS;
                r_len  <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_hash <= n_hash;
                r_len  <= n_len;
                r_ovf  <= n_ovf;
            end
        end
    end
endmodule

// ===== rtl/hst_back.sv =====
// Back end: home slot, probe sweep, key compare and insert over the table memories.
module hst_back #(
    parameter int TABLE_DEPTH    = 256,
    parameter int MAX_NAME_CHARS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_job_valid,
    input  hst_pkg::t_job                        i_job,
    input  logic [$clog2(MAX_NAME_CHARS+1)-1:0]  i_job_len,
    input  logic                                 i_job_bank,
    output logic                                 o_job_done,
    output logic [$clog2(2*MAX_NAME_CHARS)-1:0]  o_key_raddr,
    input  logic [7:0]                           i_key_rdata,
    output logic                                 o_res_valid,
    output hst_pkg::t_res                        o_res,
    input  logic                                 i_res_ready,
    output logic                                 o_clearing
);
    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(MAX_NAME_CHARS + 1);
    localparam int KW = $clog2(2 * MAX_NAME_CHARS);
    localparam int CD = TABLE_DEPTH * MAX_NAME_CHARS;
    localparam int CW = $clog2(CD);

    localparam logic [16:0]   DIV_D    = 17'(TABLE_DEPTH);
    localparam logic [31:0]   RECIP    = 32'((64'd1 << 32) / 64'(TABLE_DEPTH));
    localparam logic [SW-1:0] LAST_S   = SW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] LAST_B   = CW'(CD - MAX_NAME_CHARS);
    localparam logic [CW-1:0] MAXC     = CW'(MAX_NAME_CHARS);

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MOD      = 4'd2;
    localparam logic [3:0] S_HOME     = 4'd3;
    localparam logic [3:0] S_PRB_RD   = 4'd4;
    localparam logic [3:0] S_PRB_CHK  = 4'd5;
    localparam logic [3:0] S_CMP_RD   = 4'd6;
    localparam logic [3:0] S_CMP_CHK  = 4'd7;
    localparam logic [3:0] S_NEXT     = 4'd8;
    localparam logic [3:0] S_INS_RD   = 4'd9;
    localparam logic [3:0] S_INS_WR   = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;
    localparam logic [3:0] S_MOD_SUB  = 4'd12;
    localparam logic [3:0] S_MOD_FIX  = 4'd13;

    logic [3:0]    r_state;
    logic [15:0]   r_rem;
    logic [1:0]    r_dig;
    logic [63:0]   r_prod;
    logic [17:0]   r_diff;
    logic [SW-1:0] r_s;
    logic [SW-1:0] r_k;
    logic [CW-1:0] r_base;
    logic          r_free_found;
    logic [SW-1:0] r_free_s;
    logic [CW-1:0] r_free_base;
    logic [LW-1:0] r_j;
    logic [2:0]    r_status;

    logic          info_we;
    logic [LW:0]   info_wdata;
    logic [LW:0]   info_rdata;
    logic          chr_we;
    logic [7:0]    chr_rdata;
    logic [63:0]   hash_sh;
    logic [31:0]   mod_x;
    logic [32:0]   quot_d;
    logic          slot_used;
    logic [LW-1:0] slot_len;
    logic          last_char;

    // Slot information: used flag and name length.
    hst_ram #(.WIDTH(LW + 1), .DEPTH(TABLE_DEPTH)) u_info (
        .i_clk  (i_clk),
        .i_we   (info_we),
        .i_waddr(r_s),
        .i_wdata(info_wdata),
        .i_raddr(r_s),
        .o_rdata(info_rdata)
    );

    // Stored name characters, one row of MAX_NAME_CHARS per slot.
    hst_ram #(.WIDTH(8), .DEPTH(CD)) u_chars (
        .i_clk  (i_clk),
        .i_we   (chr_we),
        .i_waddr(r_base + CW'(r_j)),
        .i_wdata(i_key_rdata),
        .i_raddr(r_base + CW'(r_j)),
        .o_rdata(chr_rdata)
    );

    assign o_key_raddr = (i_job_bank ? KW'(MAX_NAME_CHARS) : KW'(0)) + KW'(r_j);
    assign slot_used   = info_rdata[LW];
    assign slot_len    = info_rdata[LW-1:0];
    assign last_char   = (r_j == i_job_len - LW'(1));

    // Hash modulo the table depth, 16 bits at a time from the top.
    // Each digit step forms x = rem * 2^16 + digit, estimates x / depth with a
    // reciprocal multiply (low by at most one), subtracts and corrects once.
    assign hash_sh = i_job.hash >> {r_dig, 4'd0};
    assign mod_x   = {r_rem, hash_sh[15:0]};
    assign quot_d  = r_prod[47:32] * DIV_D;

    // Memory writes: clearing pass, then inserts.
    always_comb begin
        info_we    = 1'b0;
        info_wdata = '0;
        chr_we     = 1'b0;
        if (r_state == S_CLR) begin
            info_we = 1'b1;
        end else if (r_state == S_INS_WR) begin
            chr_we = 1'b1;
            if (last_char) begin
                info_we    = 1'b1;
                info_wdata = {1'b1, i_job_len};
            end
        end
    end

    // Result and hand-shake toward the output register and the job queue.
    assign o_res_valid = (r_state == S_FIN);
    assign o_job_done  = (r_state == S_FIN) && i_res_ready;
    assign o_clearing  = (r_state == S_CLR);
    assign o_res.status = r_status;
    assign o_res.slot   = (r_status == hst_pkg::ST_FOUND || r_status == hst_pkg::ST_PRESENT ||
                           r_status == hst_pkg::ST_INSERTED) ? 8'(r_s) : 8'd0;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_s          <= '0;
            r_k          <= '0;
            r_free_found <= 1'b0;
            r_status     <= hst_pkg::ST_NOT_FOUND;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (r_s == LAST_S) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_s <= r_s + SW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.overflow) begin
                            r_status <= hst_pkg::ST_TOO_LONG;
                            r_state  <= S_FIN;
                        end else begin
                            r_rem   <= '0;
                            r_dig   <= 2'd3;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    r_prod  <= {32'd0, mod_x} * {32'd0, RECIP};
                    r_state <= S_MOD_SUB;
                end
                S_MOD_SUB: begin
                    r_diff  <= mod_x[17:0] - quot_d[17:0];
                    r_state <= S_MOD_FIX;
                end
                S_MOD_FIX: begin
                    r_rem <= (r_diff >= 18'(DIV_D)) ? 16'(r_diff - 18'(DIV_D)) : r_diff[15:0];
                    if (r_dig == 2'd0) begin
                        r_state <= S_HOME;
                    end else begin
                        r_dig   <= r_dig - 2'd1;
                        r_state <= S_MOD;
                    end
                end
                S_HOME: begin
                    r_s          <= r_rem[SW-1:0];
                    r_base       <= CW'(r_rem[SW-1:0]) * MAXC;
                    r_k          <= '0;
                    r_free_found <= 1'b0;
                    r_state      <= S_PRB_RD;
                end
                S_PRB_RD: begin
                    r_state <= S_PRB_CHK;
                end
                S_PRB_CHK: begin
                    r_j <= '0;
                    if (!slot_used) begin
                        if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_s     <= r_s;
                            r_free_base  <= r_base;
                        end
                        if (r_k == '0) begin
                            // An empty home slot ends the lookup at once.
                            if (i_job.cmd == hst_pkg::CMD_SEARCH) begin
                                r_status <= hst_pkg::ST_NOT_FOUND;
                                r_state  <= S_FIN;
                            end else begin
                                r_state <= S_INS_RD;
                            end
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end else if (slot_len == i_job_len) begin
                        r_state <= S_CMP_RD;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_CMP_RD: begin
                    r_state <= S_CMP_CHK;
                end
                S_CMP_CHK: begin
                    if (chr_rdata != i_key_rdata) begin
                        r_state <= S_NEXT;
                    end else if (last_char) begin
                        r_status <= (i_job.cmd == hst_pkg::CMD_INSERT) ?
                                    hst_pkg::ST_PRESENT : hst_pkg::ST_FOUND;
                        r_state  <= S_FIN;
                    end else begin
                        r_j     <= r_j + LW'(1);
                        r_state <= S_CMP_RD;
                    end
                end
                S_NEXT: begin
                    r_j <= '0;
                    if (r_k == LAST_S) begin
                        // Whole table swept without a match.
                        if (i_job.cmd == hst_pkg::CMD_SEARCH) begin
                            r_status <= hst_pkg::ST_NOT_FOUND;
                            r_state  <= S_FIN;
                        end else if (r_free_found) begin
                            r_s     <= r_free_s;
                            r_base  <= r_free_base;
                            r_state <= S_INS_RD;
                        end else begin
                            r_status <= hst_pkg::ST_FULL;
                            r_state  <= S_FIN;
                        end
                    end else begin
                        r_k     <= r_k + SW'(1);
                        r_s     <= (r_s == LAST_S) ? '0 : r_s + SW'(1);
                        r_base  <= (r_base == LAST_B) ? '0 : r_base + MAXC;
                        r_state <= S_PRB_RD;
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    if (last_char) begin
                        r_status <= hst_pkg::ST_INSERTED;
                        r_state  <= S_FIN;
                    end else begin
                        r_j     <= r_j + LW'(1);
                        r_state <= S_INS_RD;
                    end
                end
                S_FIN: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/hst_check.sv =====
// Port-level checker of the hashed symbol table and its bind.
module hst_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [2:0] o_status,
    input logic [7:0] o_slot
);
    // Reset starts the clearing pass and empties the result side.
    a_reset_full: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low right after reset");
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // Only defined status codes appear.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= hst_pkg::ST_TOO_LONG))
        else $error("undefined status code");

    // Statuses without a slot carry slot zero.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == hst_pkg::ST_NOT_FOUND || o_status == hst_pkg::ST_FULL ||
                    o_status == hst_pkg::ST_TOO_LONG)) |-> (o_slot == 8'd0))
        else $error("nonzero slot with a slotless status");

    // A waiting result holds until popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_slot)))
        else $error("result changed while stalled");
endmodule

bind hashed_symbol_table hst_check u_hst_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_status(o_status),
    .o_slot  (o_slot)
);
